// ===== rtl/suffix_array_prefix_doubling_unit_assert.svh =====
// Assertion macros for the suffix array unit
`ifndef SUFFIX_ARRAY_PREFIX_DOUBLING_UNIT_ASSERT_SVH
`define SUFFIX_ARRAY_PREFIX_DOUBLING_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SAPD_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SAPD_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SAPD_ASSERT(label, clk, rst_n, prop, msg)
`define SAPD_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/sapd_pkg.sv =====
// Shared constants and types for the suffix array unit
`default_nettype none
package sapd_pkg;
	localparam int MaxLen = 63;
	localparam int ExtLen = MaxLen + 1;
	localparam int PosW = 6;
	localparam int LenW = 7;
	localparam int SymW = 9;
	localparam int Buckets = 257;
	localparam int BktW = 9;
	typedef logic [PosW-1:0] pos_t;
	typedef logic [LenW-1:0] len_t;
	typedef logic [SymW-1:0] sym_t;
endpackage
`default_nettype wire

// ===== rtl/sapd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read
`default_nettype none
module sapd_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/suffix_array_prefix_doubling_unit.sv =====
// Top level: text loading, doubling sequencer and result stream
// Usage:
//  Input channel (in_valid/in_stall): one text byte per transaction;
//  end_of_text marks the last byte and starts construction. Up to 63 bytes
//  are kept, later ones are dropped and flag truncated on every result.
//  Bytes are taken back to back while loading. After end_of_text the block
//  stalls its input while it builds the suffix array over n = len+1 entries,
//  one RAM access per port per cycle: identity fill, bucket clear, count,
//  prefix sums, place, renumber, copy and check for the symbol sort; then
//  for k = 1, 2, 4 .. < n (ceil(log2 n) rounds) shift, clear, count,
//  prefix, place, renumber, copy and check in each round.
//  Results (out_valid/out_stall): one transaction per sorted suffix, the
//  sentinel suffix omitted, last_of_run on the final one. A stall holds the
//  current result; the next text is taken in the cycle after the last result
//  is accepted.
//  Reset (arst_n low) empties the text buffer and the output register.
`default_nettype none
module suffix_array_prefix_doubling_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire logic [7:0] text_byte,
	input  wire logic end_of_text,
	output logic      out_valid,
	input  wire logic out_stall,
	output logic [5:0] suffix_start,
	output logic      last_of_run,
	output logic      truncated
);
	import sapd_pkg::*;

	typedef enum logic [13:0] {
		ST_LOAD   = 14'b00000000000001,
		ST_CLR    = 14'b00000000000010, // clear buckets
		ST_CNT    = 14'b00000000000100, // count keys of shifted order
		ST_PFX    = 14'b00000000001000, // prefix sums
		ST_PLACE  = 14'b00000000010000, // place, descending
		ST_RANK   = 14'b00000000100000, // renumber classes
		ST_COPY   = 14'b00000001000000, // new class -> class
		ST_SHIFT  = 14'b00000010000000, // build shifted order
		ST_EMIT   = 14'b00000100000000,
		ST_WAIT   = 14'b00001000000000,
		ST_INIT   = 14'b00010000000000, // shifted order = identity for first sort
		ST_FIN    = 14'b00100000000000,
		ST_CHK    = 14'b01000000000000,
		ST_IDLE2  = 14'b10000000000000
	} state_t;

	state_t state_q;
	len_t len_q;
	logic ovf_q;
	logic first_q; // initial symbol sort
	pos_t n1_q;    // n-1 where n = len+1 (n <= 64)
	logic [LenW-1:0] k_q;
	logic [BktW-1:0] classes_q;
	logic [BktW-1:0] idx_q;  // pass counter
	logic [LenW-1:0] run_q;  // running prefix sum
	logic [PosW-1:0] prev_c1_q, prev_c2_q;
	logic [SymW-1:0] prev_sym_q;

	// RAM ports
	logic txt_we; pos_t txt_wa, txt_ra; logic [7:0] txt_wd, txt_rd;
	logic ord_we; pos_t ord_wa, ord_ra, ord_wd, ord_rd;
	logic sh_we;  pos_t sh_wa, sh_ra, sh_wd, sh_rd;
	logic cls_we; pos_t cls_wa, cls_ra, cls_wd, cls_rd;
	logic cl2_we; pos_t cl2_wa, cl2_ra, cl2_wd, cl2_rd;
	logic ncl_we; pos_t ncl_wa, ncl_ra, ncl_wd, ncl_rd;
	logic bkt_we; logic [BktW-1:0] bkt_wa, bkt_ra; logic [LenW-1:0] bkt_wd, bkt_rd;

	sapd_ram #(.Width(8), .Depth(ExtLen)) u_txt (.clk, .we(txt_we), .waddr(txt_wa),
		.wdata(txt_wd), .raddr(txt_ra), .rdata(txt_rd));
	sapd_ram #(.Width(PosW), .Depth(ExtLen)) u_ord (.clk, .we(ord_we), .waddr(ord_wa),
		.wdata(ord_wd), .raddr(ord_ra), .rdata(ord_rd));
	sapd_ram #(.Width(PosW), .Depth(ExtLen)) u_sh (.clk, .we(sh_we), .waddr(sh_wa),
		.wdata(sh_wd), .raddr(sh_ra), .rdata(sh_rd));
	// two copies of class so that two entries are read each cycle
	sapd_ram #(.Width(PosW), .Depth(ExtLen)) u_cls (.clk, .we(cls_we), .waddr(cls_wa),
		.wdata(cls_wd), .raddr(cls_ra), .rdata(cls_rd));
	sapd_ram #(.Width(PosW), .Depth(ExtLen)) u_cl2 (.clk, .we(cl2_we), .waddr(cl2_wa),
		.wdata(cl2_wd), .raddr(cl2_ra), .rdata(cl2_rd));
	sapd_ram #(.Width(PosW), .Depth(ExtLen)) u_ncl (.clk, .we(ncl_we), .waddr(ncl_wa),
		.wdata(ncl_wd), .raddr(ncl_ra), .rdata(ncl_rd));
	// bucket counts, one read-modify-write per element
	sapd_ram #(.Width(LenW), .Depth(Buckets)) u_bkt (.clk, .we(bkt_we), .waddr(bkt_wa),
		.wdata(bkt_wd), .raddr(bkt_ra), .rdata(bkt_rd));

	// Element steps: 0 address order/shifted, 1 latch element, 2 address
	// text/class, 3 text/class data (address bucket), 4 bucket data.
	logic [2:0] step_q;
	pos_t pa_q;         // element address latched from first read
	pos_t i_pos;
	logic in_acc, out_acc;
	logic [SymW-1:0] sym;
	pos_t ka;           // k as position (mod 64)
	pos_t n_pos;        // n mod 64 (n=64 -> 0, wraps fine)
	pos_t shifted;
	pos_t addk;
	logic [SymW-1:0] key;
	logic [LenW-1:0] bkt_dec;
	logic [LenW-1:0] pfx_sum;
	logic [BktW-1:0] bkt_last;

	assign i_pos = idx_q[PosW-1:0];
	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign in_stall = (state_q != ST_LOAD);
	assign ka = k_q[PosW-1:0];
	assign n_pos = n1_q + 1'b1;

	// symbol of position pa_q given text byte read
	always_comb begin
		sym = (pa_q == n1_q) ? '0 : {1'b0, txt_rd} + 1'b1;
		shifted = (pa_q >= ka && k_q < ExtLen) ? pa_q - ka : pa_q + n_pos - ka;
		addk = ({1'b0, pa_q} + {1'b0, ka} >= {1'b0, n_pos} + (n_pos == '0 ? 7'd64 : 7'd0))
			? pa_q + ka - n_pos : pa_q + ka;
		key = first_q ? sym : {3'b0, cls_rd};
		bkt_dec = bkt_rd - 1'b1;
		pfx_sum = run_q + bkt_rd;
		// symbol sort spans every byte value, later rounds at most n classes
		bkt_last = first_q ? BktW'(Buckets - 1) : BktW'(n1_q);
	end

	always_comb begin
		txt_we = in_acc && len_q < MaxLen;
		txt_wa = len_q[PosW-1:0];
		txt_wd = text_byte;
		txt_ra = pa_q;
		ord_we = 1'b0; ord_wa = i_pos; ord_wd = pa_q; ord_ra = i_pos;
		sh_we = 1'b0;  sh_wa = i_pos;  sh_wd = shifted; sh_ra = i_pos;
		cls_we = 1'b0; cls_wa = i_pos; cls_wd = ncl_rd; cls_ra = pa_q;
		cl2_we = 1'b0; cl2_wa = i_pos; cl2_wd = ncl_rd; cl2_ra = addk;
		ncl_we = 1'b0; ncl_wa = pa_q;  ncl_wd = '0; ncl_ra = i_pos;
		bkt_we = 1'b0; bkt_wa = key; bkt_wd = bkt_rd + 1'b1; bkt_ra = key;
		case (state_q)
			ST_INIT: begin
				sh_we = 1'b1; sh_wd = i_pos;
			end
			ST_SHIFT: begin
				sh_we = (step_q == 3'd2);
			end
			ST_CLR: begin
				bkt_we = 1'b1; bkt_wa = idx_q; bkt_wd = '0;
			end
			ST_CNT: begin
				bkt_we = (step_q == 3'd4);
			end
			ST_PFX: begin
				bkt_ra = idx_q; bkt_wa = idx_q;
				bkt_we = (step_q == 3'd1); bkt_wd = pfx_sum;
			end
			ST_PLACE: begin
				ord_we = (step_q == 3'd4); ord_wa = bkt_dec[PosW-1:0]; ord_wd = pa_q;
				bkt_we = (step_q == 3'd4); bkt_wd = bkt_dec;
			end
			ST_RANK: begin
				ncl_we = (step_q == 3'd3);
				ncl_wd = (i_pos == '0) ? '0 :
					(first_q ? (sym != prev_sym_q ? classes_q[PosW-1:0]
						: classes_q[PosW-1:0] - 1'b1)
					: ((cls_rd != prev_c1_q || cl2_rd != prev_c2_q)
						? classes_q[PosW-1:0] : classes_q[PosW-1:0] - 1'b1));
			end
			ST_COPY: begin
				cls_we = (step_q == 3'd1); cl2_we = (step_q == 3'd1);
			end
			default: begin
			end
		endcase
	end

	logic [LenW:0] n_full;
	assign n_full = {1'b0, len_q} + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			len_q <= '0;
			ovf_q <= 1'b0;
			first_q <= 1'b1;
			n1_q <= '0;
			k_q <= '0;
			classes_q <= '0;
			idx_q <= '0;
			step_q <= '0;
			pa_q <= '0;
			run_q <= '0;
			prev_c1_q <= '0;
			prev_c2_q <= '0;
			prev_sym_q <= '0;
			out_valid <= 1'b0;
			last_of_run <= 1'b0;
			truncated <= 1'b0;
			suffix_start <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (len_q < MaxLen) begin
							len_q <= len_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						if (end_of_text) begin
							n1_q <= (len_q < MaxLen) ? pos_t'(len_q + 1'b1) : pos_t'(len_q);
							first_q <= 1'b1;
							k_q <= '0;
							idx_q <= '0;
							step_q <= '0;
							state_q <= ST_INIT;
						end
					end
				end
				ST_INIT: begin
					// shifted order = identity for the symbol sort
					if (i_pos == n1_q) begin
						idx_q <= '0;
						state_q <= ST_CLR;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_SHIFT: begin
					if (step_q == 3'd1) begin
						pa_q <= ord_rd;
					end
					if (step_q != 3'd2) begin
						step_q <= step_q + 1'b1;
					end else begin
						step_q <= '0;
						if (i_pos == n1_q) begin
							idx_q <= '0;
							state_q <= ST_CLR;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_CLR: begin
					if (idx_q == bkt_last) begin
						idx_q <= '0;
						step_q <= '0;
						state_q <= ST_CNT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_CNT: begin
					if (step_q == 3'd1) begin
						pa_q <= sh_rd;
					end
					if (step_q != 3'd4) begin
						step_q <= step_q + 1'b1;
					end else begin
						step_q <= '0;
						if (i_pos == n1_q) begin
							idx_q <= '0;
							run_q <= '0;
							state_q <= ST_PFX;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_PFX: begin
					if (step_q == 3'd0) begin
						step_q <= 3'd1;
					end else begin
						step_q <= '0;
						run_q <= pfx_sum;
						if (idx_q == bkt_last) begin
							idx_q <= BktW'(n1_q);
							state_q <= ST_PLACE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_PLACE: begin
					if (step_q == 3'd1) begin
						pa_q <= sh_rd;
					end
					if (step_q != 3'd4) begin
						step_q <= step_q + 1'b1;
					end else begin
						step_q <= '0;
						if (i_pos == '0) begin
							idx_q <= '0;
							state_q <= ST_RANK;
						end else begin
							idx_q <= idx_q - 1'b1;
						end
					end
				end
				ST_RANK: begin
					if (step_q == 3'd1) begin
						pa_q <= ord_rd;
					end
					if (step_q != 3'd3) begin
						step_q <= step_q + 1'b1;
					end else begin
						step_q <= '0;
						prev_sym_q <= sym;
						prev_c1_q <= cls_rd;
						prev_c2_q <= cl2_rd;
						if (i_pos == '0) begin
							classes_q <= BktW'(1);
						end else if (first_q ? (sym != prev_sym_q)
								: (cls_rd != prev_c1_q || cl2_rd != prev_c2_q)) begin
							classes_q <= classes_q + 1'b1;
						end
						if (i_pos == n1_q) begin
							idx_q <= '0;
							state_q <= ST_COPY;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_COPY: begin
					// st0: read new_class[i]; st1: write both class copies
					if (step_q == 3'd0) begin
						step_q <= 3'd1;
					end else begin
						step_q <= '0;
						if (i_pos == n1_q) begin
							idx_q <= '0;
							state_q <= ST_CHK;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_CHK: begin
					first_q <= 1'b0;
					step_q <= '0;
					k_q <= first_q ? 7'd1 : {k_q[LenW-2:0], 1'b0};
					if ((first_q ? 8'd1 : {k_q, 1'b0}) < n_full) begin
						idx_q <= '0;
						state_q <= ST_SHIFT;
					end else begin
						idx_q <= BktW'(1);
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					// order read data for idx is valid now
					if (!out_valid || out_acc) begin
						out_valid <= 1'b1;
						suffix_start <= ord_rd;
						last_of_run <= (i_pos == n1_q);
						truncated <= ovf_q;
						if (i_pos == n1_q) begin
							state_q <= ST_WAIT;
						end else begin
							idx_q <= idx_q + 1'b1;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_WAIT: begin
					if (out_acc) begin
						out_valid <= 1'b0;
						len_q <= '0;
						ovf_q <= 1'b0;
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
			if (out_acc && state_q != ST_WAIT && state_q != ST_FIN) begin
				out_valid <= 1'b0;
			end
		end
	end

	`include "suffix_array_prefix_doubling_unit_assert.svh"
	`SAPD_NEVER(a_no_load_busy, clk, arst_n, in_acc && out_valid, "input taken while busy")
	`SAPD_ASSERT(a_last_ends, clk, arst_n, out_acc && last_of_run |=> !out_valid, "after last")
	`SAPD_NEVER(a_len_cap, clk, arst_n, len_q > MaxLen, "text length beyond capacity")
endmodule
`default_nettype wire

// ===== dv/sapd_checker.sv =====
// Checker: watches both channels, predicts the suffix arrays and compares results
module sapd_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_stall,
	input  wire logic [7:0] text_byte,
	input  wire logic       end_of_text,
	input  wire logic       out_valid,
	input  wire logic       out_stall,
	input  wire logic [5:0] suffix_start,
	input  wire logic       last_of_run,
	input  wire logic       truncated,
	output int              fail_count,
	output int              pending_count,
	output int              suffix_count,
	output int              text_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import sapd_pkg::*;

	typedef struct packed {
		pos_t start;
		logic last;
		logic trunc;
	} suffix_t;

	suffix_t expected_suffixes[$];
	logic [7:0] text_buf[MaxLen];
	int text_len;
	bit dropped;

	// Sentinel is symbol 0, bytes are byte+1
	function automatic int symbol_of(int i, int n);
		if (i + 1 >= n) return 0;
		return int'(text_buf[i]) + 1;
	endfunction

	// Prefix doubling with counting sorts over cyclic shifts
	task automatic sort_suffixes();
		int n, k, classes, p, q, c, a, b, an, bn;
		int ord[ExtLen];
		int cls[ExtLen];
		int shf[ExtLen];
		int ncl[ExtLen];
		int cnt[Buckets + MaxLen + 2];
		suffix_t s;
		n = text_len + 1;
		foreach (cnt[i]) cnt[i] = 0;
		for (int i = 0; i < n; i++) cnt[symbol_of(i, n)]++;
		for (int i = 1; i <= 256; i++) cnt[i] += cnt[i-1];
		for (int i = 0; i < n; i++) begin
			p = symbol_of(i, n);
			cnt[p]--;
			ord[cnt[p]] = i;
		end
		cls[ord[0]] = 0;
		classes = 1;
		for (int i = 1; i < n; i++) begin
			if (symbol_of(ord[i], n) != symbol_of(ord[i-1], n)) classes++;
			cls[ord[i]] = classes - 1;
		end
		for (k = 1; k < n; k = k << 1) begin
			for (int i = 0; i < n; i++) begin
				p = ord[i];
				shf[i] = (p >= k) ? p - k : p + n - k;
			end
			foreach (cnt[i]) cnt[i] = 0;
			for (int i = 0; i < n; i++) cnt[cls[shf[i]]]++;
			for (int i = 1; i < classes; i++) cnt[i] += cnt[i-1];
			for (int i = n; i > 0; i--) begin
				q = shf[i-1];
				c = cls[q];
				cnt[c]--;
				ord[cnt[c]] = q;
			end
			ncl[ord[0]] = 0;
			classes = 1;
			for (int i = 1; i < n; i++) begin
				a = ord[i];
				b = ord[i-1];
				an = (a + k) % n;
				bn = (b + k) % n;
				if (cls[a] != cls[b] || cls[an] != cls[bn]) classes++;
				ncl[a] = classes - 1;
			end
			for (int i = 0; i < n; i++) cls[i] = ncl[i];
		end
		for (int r = 0; r < n - 1; r++) begin
			s.start = pos_t'(ord[r+1]);
			s.last = (r == n - 2);
			s.trunc = dropped;
			expected_suffixes.push_back(s);
		end
	endtask

	task automatic report(string what, int got, int want);
		$display("MISMATCH t=%0t %s: got %0d expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pending_count = 0;
		suffix_count = 0;
		text_count = 0;
		text_len = 0;
		dropped = 0;
	end

	always @(posedge clk) begin
		suffix_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				if (text_len < MaxLen) begin
					text_buf[text_len] = text_byte;
					text_len++;
				end else begin
					dropped = 1;
				end
				if (end_of_text) begin
					sort_suffixes();
					text_len = 0;
					dropped = 0;
					text_count++;
				end
			end
			if (out_valid && !out_stall) begin
				suffix_count++;
				if (expected_suffixes.size() == 0) begin
					report("unexpected result, suffix_start", suffix_start, -1);
				end else begin
					want = expected_suffixes.pop_front();
					if (suffix_start !== want.start)
						report("suffix_start", suffix_start, want.start);
					if (last_of_run !== want.last)
						report("last_of_run", last_of_run, want.last);
					if (truncated !== want.trunc)
						report("truncated", truncated, want.trunc);
				end
			end
			pending_count = expected_suffixes.size();
		end
	end
endmodule

// ===== dv/tb_suffix_array_prefix_doubling_unit.sv =====
// Testbench top: text stimulus, handshake idling, watchdog and verdict
module tb_suffix_array_prefix_doubling_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WatchdogLimit = 100000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [7:0] text_byte = 0;
	logic end_of_text = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [5:0] suffix_start;
	logic last_of_run;
	logic truncated;
	int fail_count, pending_count, suffix_count, text_count;
	int byte_count = 0;
	int idle_cycles = 0;
	bit hold_off = 0;

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	suffix_array_prefix_doubling_unit u_dut (.*);

	sapd_checker u_chk (.*);

	// One byte transaction, with a random gap first; valid stays up after
	// acceptance so that the next byte can follow directly
	task automatic send_byte(logic [7:0] b, logic eot);
		int gap;
		gap = $urandom_range(0, 5);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		text_byte <= b;
		end_of_text <= eot;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		byte_count++;
	endtask

	task automatic send_text(int len, int mode);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			case (mode)
				0: b = 8'($urandom);
				1: b = 8'($urandom_range(0, 2));
				2: b = 8'hff;
				3: b = 8'h00;
				default: b = 8'(i % 2 ? 8'hff : 8'h00);
			endcase
			send_byte(b, i == len - 1);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
	endtask

	// Receiver: a random stall before each result, or a long hold-off
	initial begin
		int wait_n;
		forever begin
			wait_n = $urandom_range(0, 5);
			if (wait_n > 0 || hold_off) begin
				out_stall <= 1;
				repeat (wait_n) @(posedge clk);
				while (hold_off) @(posedge clk);
			end
			out_stall <= 0;
			@(posedge clk);
			while (!(out_valid && !out_stall)) @(posedge clk);
		end
	end

	// Watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WatchdogLimit) begin
			$display("watchdog expired");
			$display("suffix_array_prefix_doubling_unit test failed");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed texts: single bytes, extremes and repeats
		send_text(1, 3);
		send_text(1, 2);
		send_text(2, 4);
		send_text(5, 2);
		send_text(4, 1);
		send_text(6, 0);
		wait_drained();
		// long receiver hold-off while the next texts are offered
		hold_off = 1;
		fork
			begin
				repeat (600) @(posedge clk);
				hold_off = 0;
			end
			begin
				send_text(3, 0);
				send_text(3, 1);
				send_text(2, 0);
			end
		join
		wait_drained();
		send_text(63, 0);
		send_text(64, 1);
		// random short texts
		while (byte_count < 170) begin
			send_text($urandom_range(1, 12), $urandom_range(0, 4));
		end
		wait_drained();
		repeat (100) @(posedge clk);
		$display("Sent %0d bytes in %0d texts, checked %0d sorted suffixes.",
			byte_count, text_count, suffix_count);
		$display("Texts ranged from one byte to overfull, under random and long output stalls.");
		if (fail_count == 0 && pending_count == 0) begin
			$display("suffix_array_prefix_doubling_unit test passed");
		end else begin
			$display("suffix_array_prefix_doubling_unit test failed");
		end
		$finish;
	end
endmodule
